// ===== sv/scfc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sparse constraint feasibility check.
// No dependencies; used by the interfaces and all scfc modules.
package scfc_pkg;

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 10;
    localparam int VAL_W   = 32;
    localparam int TOL_W   = 16;
    localparam int SUM_OUT_W = 48;
    localparam int BND_W   = VAL_W + 2;   // rhs +/- tolerance
    localparam int PROD_W  = 2 * VAL_W;
    localparam int FRAC_W  = 16;

    // Commands
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TERM  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

    // Row senses
    localparam logic [1:0] SENSE_EQ   = 2'd0;
    localparam logic [1:0] SENSE_LE   = 2'd1;
    localparam logic [1:0] SENSE_GE   = 2'd2;
    localparam logic [1:0] SENSE_FREE = 2'd3;

    // Register map
    localparam int          APB_AW        = 3;
    localparam int          APB_DW        = 32;
    localparam logic        REG_TOLERANCE = 1'b0;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

    localparam logic signed [SUM_OUT_W-1:0] ROW_SUM_MAX = {1'b0, {(SUM_OUT_W-1){1'b1}}};
    localparam logic signed [SUM_OUT_W-1:0] ROW_SUM_MIN = {1'b1, {(SUM_OUT_W-1){1'b0}}};

    // Stage 1: accepted request plus operands
    typedef struct packed {
        logic                    term;
        logic                    clr;
        logic                    last_term;
        logic                    last_row;
        logic [1:0]              sense;
        logic                    in_range;
        logic signed [VAL_W-1:0] coef;
        logic signed [VAL_W-1:0] rhs;
    } t_s1;

    // Control passed from the accumulator to the evaluator
    typedef struct packed {
        logic       res;
        logic       clr;
        logic       last_row;
        logic [1:0] sense;
    } t_ctl;

    typedef struct packed {
        logic signed [SUM_OUT_W-1:0] row_sum;
        logic                        row_violated;
        logic                        solution_admissible;
        logic                        check_done;
    } t_res;

endpackage

// ===== sv/scfc_if.sv =====
`timescale 1ns / 1ps
// Request and result channel interfaces (valid/ready handshake).
// Depends on scfc_pkg.
interface scfc_req_if;
    logic                              valid;
    logic                              ready;
    logic [scfc_pkg::CMD_W-1:0]        cmd;
    logic [scfc_pkg::IDX_W-1:0]        var_index;
    logic signed [scfc_pkg::VAL_W-1:0] value;
    logic signed [scfc_pkg::VAL_W-1:0] coefficient;
    logic                              last_term;
    logic                              last_row;
    logic [1:0]                        sense;
    logic signed [scfc_pkg::VAL_W-1:0] rhs;

    modport source (output valid, cmd, var_index, value, coefficient, last_term,
                    last_row, sense, rhs, input ready);
    modport sink   (input valid, cmd, var_index, value, coefficient, last_term,
                    last_row, sense, rhs, output ready);
endinterface

interface scfc_res_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [scfc_pkg::SUM_OUT_W-1:0] row_sum;
    logic                                  row_violated;
    logic                                  solution_admissible;
    logic                                  check_done;

    modport source (output valid, row_sum, row_violated, solution_admissible,
                    check_done, input ready);
    modport sink   (input valid, row_sum, row_violated, solution_admissible,
                    check_done, output ready);
endinterface

// ===== sv/scfc_vmem.sv =====
`timescale 1ns / 1ps
// Variable value memory: one write port, one registered read port.
// Depends on scfc_pkg.
module scfc_vmem #(
    parameter int NUM_VARIABLES = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [$clog2(NUM_VARIABLES)-1:0]  i_waddr,
    input  logic signed [scfc_pkg::VAL_W-1:0] i_wdata,
    input  logic                              i_re,
    input  logic [$clog2(NUM_VARIABLES)-1:0]  i_raddr,
    output logic signed [scfc_pkg::VAL_W-1:0] o_rdata
);

    logic signed [scfc_pkg::VAL_W-1:0] r_mem [NUM_VARIABLES];
    logic signed [scfc_pkg::VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds between reads so a stalled pipeline keeps its operand
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/scfc_mac.sv =====
`timescale 1ns / 1ps
// Multiply stage and saturating row accumulator; also forms rhs +/- tolerance.
// Depends on scfc_pkg.
module scfc_mac #(
    parameter int ACC_WIDTH = 48
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  scfc_pkg::t_s1                       i_s1,
    input  logic signed [scfc_pkg::VAL_W-1:0]   i_rdata,
    input  logic [scfc_pkg::TOL_W-1:0]          i_tol,
    output scfc_pkg::t_ctl                      o_ctl,
    output logic signed [ACC_WIDTH-1:0]         o_sum,
    output logic signed [scfc_pkg::BND_W-1:0]   o_bhi,
    output logic signed [scfc_pkg::BND_W-1:0]   o_blo
);

    localparam int SUM_W = ((ACC_WIDTH > scfc_pkg::SUM_OUT_W) ?
                            ACC_WIDTH : scfc_pkg::SUM_OUT_W) + 1;
    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    // stage 2
    logic                                r_s2_term;
    logic                                r_s2_clr;
    logic                                r_s2_last_term;
    logic                                r_s2_last_row;
    logic [1:0]                          r_s2_sense;
    logic signed [scfc_pkg::PROD_W-1:0]  r_prod;
    logic signed [scfc_pkg::BND_W-1:0]   r_s2_bhi;
    logic signed [scfc_pkg::BND_W-1:0]   r_s2_blo;

    // stage 3
    scfc_pkg::t_ctl                      r_ctl;
    logic signed [ACC_WIDTH-1:0]         r_sum;
    logic signed [scfc_pkg::BND_W-1:0]   r_bhi;
    logic signed [scfc_pkg::BND_W-1:0]   r_blo;
    logic signed [ACC_WIDTH-1:0]         r_acc;

    logic signed [scfc_pkg::VAL_W-1:0]   opnd;
    logic signed [scfc_pkg::PROD_W-1:0]  prod;
    logic signed [scfc_pkg::BND_W-1:0]   tol_ext;
    logic signed [scfc_pkg::SUM_OUT_W-1:0] prod_q;
    logic signed [SUM_W-1:0]             wide_sum;
    logic signed [ACC_WIDTH-1:0]         trunc_sum;
    logic signed [ACC_WIDTH-1:0]         n_sum;

    // out-of-range index reads as zero
    assign opnd    = i_s1.in_range ? i_rdata : '0;
    assign prod    = scfc_pkg::PROD_W'(i_s1.coef) * scfc_pkg::PROD_W'(opnd);
    assign tol_ext = scfc_pkg::BND_W'($signed({1'b0, i_tol}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_term <= 1'b0;
            r_s2_clr  <= 1'b0;
        end else if (i_en) begin
            r_s2_term <= i_s1.term;
            r_s2_clr  <= i_s1.clr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_last_term <= i_s1.last_term;
            r_s2_last_row  <= i_s1.last_row;
            r_s2_sense     <= i_s1.sense;
            r_prod         <= prod;
            r_s2_bhi       <= scfc_pkg::BND_W'(i_s1.rhs) + tol_ext;
            r_s2_blo       <= scfc_pkg::BND_W'(i_s1.rhs) - tol_ext;
        end
    end

    // Q32.32 -> Q32.16 with floor is an arithmetic shift
    assign prod_q    = r_prod[scfc_pkg::PROD_W-1:scfc_pkg::FRAC_W];
    assign wide_sum  = SUM_W'(r_acc) + SUM_W'(prod_q);
    assign trunc_sum = wide_sum[ACC_WIDTH-1:0];

    always_comb begin
        n_sum = trunc_sum;
        if (SUM_W'(trunc_sum) != wide_sum) begin
            n_sum = wide_sum[SUM_W-1] ? ACC_MIN : ACC_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_ctl.res   <= 1'b0;
            r_ctl.clr   <= 1'b0;
        end else if (i_en) begin
            r_ctl.res <= r_s2_term && r_s2_last_term;
            r_ctl.clr <= r_s2_clr;
            if (r_s2_clr) begin
                r_acc <= '0;
            end else if (r_s2_term) begin
                r_acc <= r_s2_last_term ? '0 : n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl.last_row <= r_s2_last_row;
            r_ctl.sense    <= r_s2_sense;
            r_sum          <= n_sum;
            r_bhi          <= r_s2_bhi;
            r_blo          <= r_s2_blo;
        end
    end

    assign o_ctl = r_ctl;
    assign o_sum = r_sum;
    assign o_bhi = r_bhi;
    assign o_blo = r_blo;

endmodule

// ===== sv/scfc_eval.sv =====
`timescale 1ns / 1ps
// Row evaluation, sticky violation flag, result register and skid stage.
// Depends on scfc_pkg and scfc_if.
module scfc_eval #(
    parameter int ACC_WIDTH = 48
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  scfc_pkg::t_ctl                     i_ctl,
    input  logic signed [ACC_WIDTH-1:0]        i_sum,
    input  logic signed [scfc_pkg::BND_W-1:0]  i_bhi,
    input  logic signed [scfc_pkg::BND_W-1:0]  i_blo,
    output logic                               o_advance,
    scfc_res_if.source                         o_res
);

    localparam int SUM_W = ((ACC_WIDTH > scfc_pkg::SUM_OUT_W) ?
                            ACC_WIDTH : scfc_pkg::SUM_OUT_W) + 1;

    logic               r_viol_seen;
    logic               r_out_valid;
    logic               r_skid_valid;
    scfc_pkg::t_res     r_out;
    scfc_pkg::t_res     r_skid;

    logic signed [SUM_W-1:0]              s_ext;
    logic signed [scfc_pkg::SUM_OUT_W-1:0] s_trunc;
    logic               above;
    logic               below;
    logic               viol;
    scfc_pkg::t_res     res;

    assign s_ext   = SUM_W'(i_sum);
    assign s_trunc = s_ext[scfc_pkg::SUM_OUT_W-1:0];
    assign above   = s_ext > SUM_W'(i_bhi);
    assign below   = s_ext < SUM_W'(i_blo);

    always_comb begin
        case (i_ctl.sense)
            scfc_pkg::SENSE_EQ: viol = above || below;
            scfc_pkg::SENSE_LE: viol = above;
            scfc_pkg::SENSE_GE: viol = below;
            default:            viol = 1'b0;
        endcase
    end

    always_comb begin
        res.row_sum = s_trunc;
        if (SUM_W'(s_trunc) != s_ext) begin
            res.row_sum = s_ext[SUM_W-1] ? scfc_pkg::ROW_SUM_MIN : scfc_pkg::ROW_SUM_MAX;
        end
        res.row_violated        = viol;
        res.solution_admissible = !(r_viol_seen || viol);
        res.check_done          = i_ctl.last_row;
    end

    // pipeline moves whenever the skid stage is empty
    assign o_advance = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_viol_seen  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (o_advance) begin
                if (i_ctl.clr) begin
                    r_viol_seen <= 1'b0;
                end else if (i_ctl.res && viol) begin
                    r_viol_seen <= 1'b1;
                end
            end
            if (r_out_valid && o_res.ready) begin
                // output drains; refill from skid or from a new row result
                r_out_valid  <= r_skid_valid || (o_advance && i_ctl.res);
                r_skid_valid <= 1'b0;
            end else if (o_advance && i_ctl.res) begin
                if (r_out_valid) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_valid && o_res.ready && r_skid_valid) begin
            r_out <= r_skid;
        end
        if (o_advance && i_ctl.res) begin
            if (!r_out_valid || o_res.ready) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_res.valid               = r_out_valid;
    assign o_res.row_sum             = r_out.row_sum;
    assign o_res.row_violated        = r_out.row_violated;
    assign o_res.solution_admissible = r_out.solution_admissible;
    assign o_res.check_done          = r_out.check_done;

endmodule

// ===== sv/sparse_constraint_feasibility_check.sv =====
`timescale 1ns / 1ps
// Sparse constraint feasibility check, top level. Depends on scfc_pkg, scfc_if,
// scfc_vmem, scfc_mac and scfc_eval.
// A last-term request passes stage 1, stage 2 and stage 3, then shows in the result register.
// Throughput: one request per cycle unless the result skid stage is occupied; the accumulator loop sets it.
// Reset (sync, active low) clears the pipeline, accumulator, violation flag and
// sets tolerance to 66; the value memory is not cleared and must be written first.
module sparse_constraint_feasibility_check #(
    parameter int NUM_VARIABLES = 1024,
    parameter int ACC_WIDTH     = 48
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [scfc_pkg::APB_AW-1:0]     paddr,
    input  logic [scfc_pkg::APB_DW-1:0]     pwdata,
    output logic [scfc_pkg::APB_DW-1:0]     prdata,
    output logic                            pready,
    // request and result channels
    scfc_req_if.sink                        i_req,
    scfc_res_if.source                      o_res
);

    localparam int AW = $clog2(NUM_VARIABLES);

    logic [scfc_pkg::TOL_W-1:0] r_tol;
    logic                       reg_sel;
    logic                       advance;
    logic                       accept;
    logic                       in_range;
    logic [AW-1:0]              addr;
    scfc_pkg::t_s1              r_s1;

    logic signed [scfc_pkg::VAL_W-1:0] rdata;
    scfc_pkg::t_ctl                    ctl;
    logic signed [ACC_WIDTH-1:0]       sum;
    logic signed [scfc_pkg::BND_W-1:0] bhi;
    logic signed [scfc_pkg::BND_W-1:0] blo;

    // ---- register file: tolerance is the only register ----
    assign reg_sel = paddr[2] == scfc_pkg::REG_TOLERANCE;
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? scfc_pkg::APB_DW'(r_tol) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= scfc_pkg::TOL_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_tol <= pwdata[scfc_pkg::TOL_W-1:0];
        end
    end

    // ---- request intake ----
    // Requests enter every cycle unless the result skid stage is occupied;
    // then every stage holds.
    assign i_req.ready = advance;
    assign accept      = i_req.valid && advance;
    assign in_range    = 32'(i_req.var_index) < NUM_VARIABLES;
    assign addr        = AW'(i_req.var_index);

    // Stage 1 lines up with the registered memory read. Writes land at the
    // accepting edge, so a term right after a write already sees the new value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.term <= 1'b0;
            r_s1.clr  <= 1'b0;
        end else if (advance) begin
            r_s1.term <= accept && (i_req.cmd == scfc_pkg::CMD_TERM);
            r_s1.clr  <= accept && (i_req.cmd == scfc_pkg::CMD_START);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1.last_term <= i_req.last_term;
            r_s1.last_row  <= i_req.last_row;
            r_s1.sense     <= i_req.sense;
            r_s1.in_range  <= in_range;
            r_s1.coef      <= i_req.coefficient;
            r_s1.rhs       <= i_req.rhs;
        end
    end

    scfc_vmem #(
        .NUM_VARIABLES(NUM_VARIABLES)
    ) u_vmem (
        .i_clk   (i_clk),
        .i_we    (accept && (i_req.cmd == scfc_pkg::CMD_WRITE) && in_range),
        .i_waddr (addr),
        .i_wdata (i_req.value),
        .i_re    (accept && (i_req.cmd == scfc_pkg::CMD_TERM)),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    // Stage 2 multiplies, stage 3 accumulates with saturation.
    scfc_mac #(
        .ACC_WIDTH(ACC_WIDTH)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_s1    (r_s1),
        .i_rdata (rdata),
        .i_tol   (r_tol),
        .o_ctl   (ctl),
        .o_sum   (sum),
        .o_bhi   (bhi),
        .o_blo   (blo)
    );

    // Row compare against rhs +/- tolerance, sticky flag, result register.
    scfc_eval #(
        .ACC_WIDTH(ACC_WIDTH)
    ) u_eval (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_sum     (sum),
        .i_bhi     (bhi),
        .i_blo     (blo),
        .o_advance (advance),
        .o_res     (o_res)
    );

endmodule

// ===== tb/scfc_row_check_monitor.sv =====
`timescale 1ns / 1ps
// Row result checker for the sparse constraint feasibility check: predicts each row result
// from the accepted requests and register writes, and compares. Depends on scfc_pkg, scfc_if.
module scfc_row_check_monitor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    scfc_req_if                         i_req,
    scfc_res_if                         i_res,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [scfc_pkg::APB_AW-1:0] i_paddr,
    input  logic [scfc_pkg::APB_DW-1:0] i_pwdata,
    input  logic [scfc_pkg::APB_DW-1:0] i_prdata,
    input  logic                        i_pready,
    output int                          o_errors,
    output int                          o_pending,
    output int                          o_rows
);
    import scfc_pkg::*;

    localparam logic [APB_AW-1:0] TOL_ADDR = APB_AW'(REG_TOLERANCE) << 2;
    localparam int MAX_PRINTED = 40;

    logic signed [VAL_W-1:0]     var_values [1024];
    logic signed [SUM_OUT_W-1:0] row_acc;
    logic                        any_violation;
    logic [TOL_W-1:0]            tol;
    t_res                        pending_rows [$];
    int                          errors;
    int                          rows_seen;

    // coefficient * value is exact, then floor-shifted down to Q48.16
    function automatic logic signed [63:0] scaled_product(input logic signed [VAL_W-1:0] c,
                                                         input logic signed [VAL_W-1:0] v);
        logic signed [63:0] p;
        p = 64'(c) * 64'(v);
        return p >>> FRAC_W;
    endfunction

    function automatic logic signed [SUM_OUT_W-1:0] saturated_sum(
        input logic signed [SUM_OUT_W-1:0] a, input logic signed [63:0] b);
        logic signed [63:0] s;
        s = 64'(a) + b;
        if (s > ROW_SUM_MAX) return ROW_SUM_MAX;
        if (s < ROW_SUM_MIN) return ROW_SUM_MIN;
        return s[SUM_OUT_W-1:0];
    endfunction

    function automatic logic row_breaks(input logic signed [SUM_OUT_W-1:0] s,
                                        input logic [1:0] sense,
                                        input logic signed [VAL_W-1:0] rhs,
                                        input logic [TOL_W-1:0] t);
        logic signed [63:0] upper;
        logic signed [63:0] lower;
        upper = 64'(rhs) + 64'($signed({1'b0, t}));
        lower = 64'(rhs) - 64'($signed({1'b0, t}));
        case (sense)
            SENSE_EQ: return (s > upper) || (s < lower);
            SENSE_LE: return s > upper;
            SENSE_GE: return s < lower;
            default:  return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("[%0t] mismatch on %s at row %0d: expected %h, got %h",
                     $realtime, what, rows_seen, want, got);
    endtask

    always @(posedge i_clk) begin
        t_res want;
        logic viol;
        if (!i_rst_n) begin
            row_acc       = '0;
            any_violation = 1'b0;
            tol           = TOL_RESET;
            pending_rows.delete();
            errors        = 0;
            rows_seen     = 0;
        end else begin
            // register port
            if (i_psel && i_penable && i_pready && i_paddr == TOL_ADDR) begin
                if (i_pwrite)
                    tol = i_pwdata[TOL_W-1:0];
                else if (i_prdata[TOL_W-1:0] !== tol)
                    report_mismatch("tolerance readback", 64'(tol), 64'(i_prdata));
            end

            // results leave before new requests can produce any
            if (i_res.valid && i_res.ready) begin
                if (pending_rows.size() == 0) begin
                    report_mismatch("unexpected result", 64'd0, 64'(i_res.row_sum));
                end else begin
                    want = pending_rows.pop_front();
                    if (i_res.row_sum !== want.row_sum)
                        report_mismatch("row_sum", 64'(want.row_sum), 64'(i_res.row_sum));
                    if (i_res.row_violated !== want.row_violated)
                        report_mismatch("row_violated", 64'(want.row_violated),
                                        64'(i_res.row_violated));
                    if (i_res.solution_admissible !== want.solution_admissible)
                        report_mismatch("solution_admissible", 64'(want.solution_admissible),
                                        64'(i_res.solution_admissible));
                    if (i_res.check_done !== want.check_done)
                        report_mismatch("check_done", 64'(want.check_done),
                                        64'(i_res.check_done));
                    rows_seen++;
                end
            end

            if (i_req.valid && i_req.ready) begin
                case (i_req.cmd)
                    CMD_WRITE: var_values[i_req.var_index] = i_req.value;
                    CMD_START: begin
                        row_acc       = '0;
                        any_violation = 1'b0;
                    end
                    CMD_TERM: begin
                        // a 10-bit index is always inside the 1024-entry store
                        row_acc = saturated_sum(row_acc,
                            scaled_product(i_req.coefficient, var_values[i_req.var_index]));
                        if (i_req.last_term) begin
                            viol = row_breaks(row_acc, i_req.sense, i_req.rhs, tol);
                            if (viol) any_violation = 1'b1;
                            want.row_sum             = row_acc;
                            want.row_violated        = viol;
                            want.solution_admissible = !any_violation;
                            want.check_done          = i_req.last_row;
                            pending_rows.push_back(want);
                            row_acc = '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
        o_errors  = errors;
        o_pending = pending_rows.size();
        o_rows    = rows_seen;
    end

endmodule

// ===== tb/sparse_constraint_feasibility_check_test.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the sparse constraint feasibility check.
// Depends on scfc_pkg, scfc_if, the block itself and scfc_row_check_monitor.
module sparse_constraint_feasibility_check_test;
    import scfc_pkg::*;

    localparam logic [APB_AW-1:0]     TOL_ADDR  = APB_AW'(REG_TOLERANCE) << 2;
    localparam logic signed [VAL_W-1:0] Q_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] Q_MIN   = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] Q_ONE   = 32'sh0001_0000;
    // Longest correct quiet spell: the HOLD_CYCLES result hold-off plus idling and
    // register access; the limit takes that several times over.
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel, penable, pwrite, pready;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata, prdata;

    scfc_req_if req_ch ();
    scfc_res_if res_ch ();

    int errors, pending, rows_done;
    int n_sent;         // requests that do something (no-ops left out)
    int n_checks;
    bit tx_idle, rx_idle;
    bit hold_req;
    bit written [1024];
    int unsigned written_list [$];

    sparse_constraint_feasibility_check dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    scfc_row_check_monitor row_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_ch),
        .i_res     (res_ch),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .i_prdata  (prdata),
        .i_pready  (pready),
        .o_errors  (errors),
        .o_pending (pending),
        .o_rows    (rows_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Result side: random back-pressure, or a long hold-off on request so the
    // pipeline fills and the request channel stalls.
    initial begin
        int hold_left;
        hold_left    = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req      = 1'b0;
                hold_left     = HOLD_CYCLES - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= !(rx_idle && $urandom_range(99) < 13);
            end
        end
    end

    // Watchdog: any cycle without a handshake on either channel or the
    // register port counts toward the limit.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (psel && penable))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d rows outstanding",
                         quiet, pending);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // One request; fields change at the falling edge, handshake seen at the rising edge.
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                         input logic signed [VAL_W-1:0] value,
                         input logic signed [VAL_W-1:0] coef,
                         input logic last_term, input logic last_row,
                         input logic [1:0] sense, input logic signed [VAL_W-1:0] rhs);
        while (tx_idle && $urandom_range(99) < 13) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= cmd;
        req_ch.var_index   <= idx;
        req_ch.value       <= value;
        req_ch.coefficient <= coef;
        req_ch.last_term   <= last_term;
        req_ch.last_row    <= last_row;
        req_ch.sense       <= sense;
        req_ch.rhs         <= rhs;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        if (cmd == CMD_WRITE && !written[idx]) begin
            written[idx] = 1'b1;
            written_list.push_back(idx);
        end
        if (cmd != CMD_NOP) n_sent++;
        if (cmd == CMD_START) n_checks++;
    endtask

    task automatic write_var(input logic [IDX_W-1:0] idx, input logic signed [VAL_W-1:0] v);
        issue(CMD_WRITE, idx, v, $urandom, 1'($urandom), 1'($urandom), 2'($urandom),
              $urandom);
    endtask

    task automatic term(input logic [IDX_W-1:0] idx, input logic signed [VAL_W-1:0] coef,
                        input logic last_term, input logic last_row,
                        input logic [1:0] sense, input logic signed [VAL_W-1:0] rhs);
        issue(CMD_TERM, idx, $urandom, coef, last_term, last_row, sense, rhs);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= TOL_ADDR;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drain all rows, give the pipeline its latency to empty, then reprogram and read back.
    task automatic set_tolerance(input logic [TOL_W-1:0] t);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
        apb_access(1'b1, APB_DW'(t));
        @(negedge i_clk);
        apb_access(1'b0, '0);
    endtask

    // Q16.16 operand mix: full range, a few units, sub-unit, extremes
    function automatic logic signed [VAL_W-1:0] rand_q();
        case ($urandom_range(5))
            1, 2: return $signed($urandom_range(524288)) - 262144;
            3:    return $signed($urandom_range(131072)) - 65536;
            4: begin
                case ($urandom_range(4))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return 0;
                    3: return 1;
                    default: return -1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_rhs();
        case ($urandom_range(4))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return $urandom;
            default: return $signed($urandom_range(1048576)) - 524288;
        endcase
    endfunction

    // A row of terms on written variables. Sometimes a stray last_row on an
    // inner term, rarely a restart that cuts the row short.
    task automatic random_row();
        int n;
        logic lr;
        logic [1:0] sense;
        n     = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
        lr    = ($urandom_range(3) == 0);
        sense = 2'($urandom_range(3));
        for (int i = 0; i < n; i++) begin
            if (i == n - 1)
                term(IDX_W'(written_list[$urandom_range(written_list.size() - 1)]), rand_q(),
                     1'b1, lr, sense, rand_rhs());
            else begin
                term(IDX_W'(written_list[$urandom_range(written_list.size() - 1)]), rand_q(),
                     1'b0, $urandom_range(9) == 0, 2'($urandom), $urandom);
                if ($urandom_range(49) == 0)
                    issue(CMD_START, IDX_W'($urandom), $urandom, $urandom, 1'($urandom),
                          1'($urandom), 2'($urandom), $urandom);
            end
        end
    endtask

    task automatic random_phase(input int n_items);
        int goal;
        int r;
        goal = n_sent + n_items;
        while (n_sent < goal) begin
            r = $urandom_range(99);
            if (r < 10)
                write_var(IDX_W'($urandom_range(1023)), rand_q());
            else if (r < 13)
                issue(CMD_NOP, IDX_W'($urandom), $urandom, $urandom, 1'($urandom),
                      1'($urandom), 2'($urandom), $urandom);
            else if (r < 16)
                issue(CMD_START, IDX_W'($urandom), $urandom, $urandom, 1'($urandom),
                      1'($urandom), 2'($urandom), $urandom);
            else
                random_row();
        end
    endtask

    initial begin
        // every input known from time zero
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_ch.valid       = 1'b0;
        req_ch.cmd         = CMD_NOP;
        req_ch.var_index   = '0;
        req_ch.value       = '0;
        req_ch.coefficient = '0;
        req_ch.last_term   = 1'b0;
        req_ch.last_row    = 1'b0;
        req_ch.sense       = SENSE_EQ;
        req_ch.rhs         = '0;
        tx_idle            = 1'b1;
        rx_idle            = 1'b1;
        hold_req           = 1'b0;
        n_sent             = 0;
        n_checks           = 0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset value of the tolerance reads back
        apb_access(1'b0, '0);

        // ---- directed part, tolerance at its reset value ----
        write_var(0, Q_MAX);
        write_var(1, Q_MIN);
        write_var(1023, Q_ONE);
        write_var(2, -Q_ONE);
        write_var(4, -1);
        issue(CMD_NOP, 5, 0, 0, 1'b1, 1'b1, SENSE_EQ, 0);   // does nothing
        issue(CMD_START, 0, 0, 0, 1'b0, 1'b0, SENSE_EQ, 0);
        // stray last_row on an inner term; sum lands exactly on rhs
        term(1023, 32'sh0003_0000, 1'b0, 1'b1, SENSE_FREE, 0);
        term(2, Q_ONE, 1'b1, 1'b0, SENSE_EQ, 32'sh0002_0000);
        // three largest products overflow the accumulator high
        term(0, Q_MAX, 1'b0, 1'b0, SENSE_EQ, 0);
        term(0, Q_MAX, 1'b0, 1'b0, SENSE_EQ, 0);
        term(0, Q_MAX, 1'b1, 1'b0, SENSE_LE, Q_MAX);
        // and low
        term(1, Q_MAX, 1'b0, 1'b0, SENSE_EQ, 0);
        term(1, Q_MAX, 1'b0, 1'b0, SENSE_EQ, 0);
        term(1, Q_MAX, 1'b1, 1'b0, SENSE_GE, Q_MIN);
        // most negative times most negative, unchecked, ends the check
        term(1, Q_MIN, 1'b1, 1'b1, SENSE_FREE, 0);
        // a row after the final row keeps the sticky flag
        term(1023, 32'sh0000_0010, 1'b1, 1'b1, SENSE_EQ, 0);
        issue(CMD_START, 1023, 0, 0, 1'b1, 1'b1, SENSE_FREE, 0);
        // tolerance edges: sum -1 against rhs 65 and 0 against rhs 66 both just pass
        term(1023, -1, 1'b1, 1'b0, SENSE_EQ, 65);
        term(1023, 0, 1'b1, 1'b0, SENSE_GE, 66);
        // just past the upper edge
        term(2, 67, 1'b1, 1'b0, SENSE_LE, -134);
        // floor of a tiny negative product
        term(4, 1, 1'b1, 1'b1, SENSE_EQ, 0);

        // ---- random phases over several tolerance settings ----
        set_tolerance(16'd0);
        hold_req = 1'b1;             // long result hold-off while requests keep coming
        random_phase(210);

        set_tolerance(16'hFFFF);
        tx_idle = 1'b0;              // back-to-back on both sides
        rx_idle = 1'b0;
        random_phase(210);
        tx_idle = 1'b1;
        rx_idle = 1'b1;

        set_tolerance(TOL_W'($urandom));
        random_phase(210);

        set_tolerance(16'd1);
        random_phase(210);

        // ---- drain ----
        req_ch.valid <= 1'b0;
        for (int w = 0; w < QUIET_LIMIT && pending != 0; w++) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("Covered %0d requests in %0d checks, %0d row results, five tolerance settings",
                 n_sent, n_checks, rows_done);
        if (pending != 0)
            $display("%0d row results never arrived", pending);
        if (errors == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sparse_constraint_feasibility_check.f =====
sv/scfc_pkg.sv
sv/scfc_if.sv
sv/scfc_vmem.sv
sv/scfc_mac.sv
sv/scfc_eval.sv
sv/sparse_constraint_feasibility_check.sv
tb/scfc_row_check_monitor.sv
tb/sparse_constraint_feasibility_check_test.sv
